FILE: sv/pwe_pkg.sv
`timescale 1ns / 1ps

package pwe_pkg;

   // image store geometry
   localparam int MAX_ROWS  = 64;
   localparam int MAX_COLS  = 64;
   localparam int MAX_HALF  = 3;
   localparam int ROW_W     = 6;
   localparam int COL_W     = 6;
   localparam int DIM_W     = 7;
   localparam int HALF_W    = 2;
   localparam int CHAN_W    = 8;
   localparam int PIX_W     = 3 * CHAN_W;
   localparam int ADDR_W    = ROW_W + COL_W;
   localparam int DEPTH     = MAX_ROWS * MAX_COLS;
   localparam int OFF_W     = HALF_W + 1;
   localparam int COORD_W   = DIM_W + 1;
   localparam int WPOS_W    = 6;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_ROWS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_COLS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_HALF = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_VALUE   = 2'd3;

   // reset values of the registers
   localparam logic [DIM_W-1:0]  RST_ROWS = 7'd64;
   localparam logic [DIM_W-1:0]  RST_COLS = 7'd64;
   localparam logic [HALF_W-1:0] RST_HALF = 2'd1;
   localparam logic [CHAN_W-1:0] RST_PAD  = 8'd0;

   // request commands
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_WINDOW = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
      logic [WPOS_W-1:0] window_pos;
      logic              is_padding;
      logic              last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic write;
      logic start;
      logic issue;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic advance;
      logic last_elem;
   } dp_status_type;

endpackage

FILE: sv/pwe_ctrl.sv
`timescale 1ns / 1ps

module pwe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_cmd,
   output logic                   req_stall,
   output pwe_pkg::dp_cmd_type    dp_cmd,
   input  pwe_pkg::dp_status_type dp_status
);
   import pwe_pkg::*;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // take items only between windows
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      dp_cmd.write = accept && (req_cmd == CMD_WRITE);
      dp_cmd.start = accept && (req_cmd == CMD_WINDOW);
      dp_cmd.issue = (state_ff == ST_RUN) && dp_status.advance;
   end

   // walk the window, one element issued per free output slot
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (dp_cmd.start) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (dp_cmd.issue && dp_status.last_elem) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/pwe_datapath.sv
`timescale 1ns / 1ps

module pwe_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [pwe_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pwe_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  pwe_pkg::req_type                    req,
   output pwe_pkg::rsp_type                    rsp,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  pwe_pkg::dp_cmd_type                 dp_cmd,
   output pwe_pkg::dp_status_type              dp_status
);
   import pwe_pkg::*;

   // configuration registers
   logic [DIM_W-1:0]  rows_ff;
   logic [DIM_W-1:0]  cols_ff;
   logic [HALF_W-1:0] half_ff;
   logic [CHAN_W-1:0] pad_ff;
   logic [DIM_W-1:0]  rows_use;
   logic [DIM_W-1:0]  cols_use;
   logic [HALF_W-1:0] half_use;

   // window walk
   logic [ROW_W-1:0]   crow_ff;
   logic [COL_W-1:0]   ccol_ff;
   logic [OFF_W-1:0]   dr_ff;
   logic [OFF_W-1:0]   dc_ff;
   logic [WPOS_W-1:0]  pos_ff;
   logic [OFF_W-1:0]   side_m1;
   logic [COORD_W-1:0] r_sum;
   logic [COORD_W-1:0] c_sum;
   logic               in_image;
   logic               wr_ok;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr;

   // pixel store and result stage
   logic [PIX_W-1:0]  mem [DEPTH];
   logic [PIX_W-1:0]  rd_data_ff;
   logic              s1_valid_ff;
   logic              s1_pad_ff;
   logic              s1_last_ff;
   logic [WPOS_W-1:0] s1_pos_ff;
   logic              advance;

   // saturate the size registers
   always_comb begin
      rows_use = (rows_ff > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_ff;
      cols_use = (cols_ff > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_ff;
      half_use = (half_ff > HALF_W'(MAX_HALF)) ? HALF_W'(MAX_HALF) : half_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= RST_ROWS;
         cols_ff <= RST_COLS;
         half_ff <= RST_HALF;
         pad_ff  <= RST_PAD;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_ROWS:  rows_ff <= csr_wdata[DIM_W-1:0];
            CSR_IMAGE_COLS:  cols_ff <= csr_wdata[DIM_W-1:0];
            CSR_WINDOW_HALF: half_ff <= csr_wdata[HALF_W-1:0];
            CSR_PAD_VALUE:   pad_ff  <= csr_wdata[CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   // image coordinates of the element being issued
   always_comb begin
      side_m1  = {half_use, 1'b0};
      r_sum    = COORD_W'(crow_ff) + COORD_W'(dr_ff) - COORD_W'(half_use);
      c_sum    = COORD_W'(ccol_ff) + COORD_W'(dc_ff) - COORD_W'(half_use);
      in_image = !r_sum[COORD_W-1] && (r_sum[DIM_W-1:0] < rows_use)
              && !c_sum[COORD_W-1] && (c_sum[DIM_W-1:0] < cols_use);
      rd_addr  = {r_sum[ROW_W-1:0], c_sum[COL_W-1:0]};
      wr_ok    = ({1'b0, req.row} < rows_use) && ({1'b0, req.col} < cols_use);
      wr_addr  = {req.row, req.col};
   end

   assign advance             = !s1_valid_ff || !rsp_stall;
   assign dp_status.advance   = advance;
   assign dp_status.last_elem = (dr_ff == side_m1) && (dc_ff == side_m1);

   // load the center, then step across each row of the window
   always_ff @(posedge clock) begin
      if (reset) begin
         dr_ff  <= '0;
         dc_ff  <= '0;
         pos_ff <= '0;
      end else if (dp_cmd.start) begin
         dr_ff  <= '0;
         dc_ff  <= '0;
         pos_ff <= '0;
      end else if (dp_cmd.issue) begin
         if (dp_status.last_elem) begin
            dr_ff  <= '0;
            dc_ff  <= '0;
            pos_ff <= '0;
         end else if (dc_ff == side_m1) begin
            dc_ff  <= '0;
            dr_ff  <= dr_ff + OFF_W'(1);
            pos_ff <= pos_ff + WPOS_W'(1);
         end else begin
            dc_ff  <= dc_ff + OFF_W'(1);
            pos_ff <= pos_ff + WPOS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.start) begin
         crow_ff <= req.row;
         ccol_ff <= req.col;
      end
   end

   // pixel store: up to one write and one read per cycle; the read holds while the result stage stalls
   always_ff @(posedge clock) begin
      if (dp_cmd.write && wr_ok) begin
         mem[wr_addr] <= {req.red_in, req.green_in, req.blue_in};
      end
      if (advance) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // result stage; hold while the consumer stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= dp_cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_pad_ff  <= !in_image;
         s1_last_ff <= dp_status.last_elem;
         s1_pos_ff  <= pos_ff;
      end
   end

   // substitute the pad value outside the image
   always_comb begin
      rsp_valid      = s1_valid_ff;
      rsp.red_out    = s1_pad_ff ? pad_ff : rd_data_ff[3*CHAN_W-1:2*CHAN_W];
      rsp.green_out  = s1_pad_ff ? pad_ff : rd_data_ff[2*CHAN_W-1:CHAN_W];
      rsp.blue_out   = s1_pad_ff ? pad_ff : rd_data_ff[CHAN_W-1:0];
      rsp.window_pos = s1_pos_ff;
      rsp.is_padding = s1_pad_ff;
      rsp.last       = s1_last_ff;
   end

endmodule

FILE: sv/padded_window_extractor.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  pwe_pkg::req_type (write pixel or window center)
// rsp      out        rsp_valid/rsp_stall  pwe_pkg::rsp_type (one window element)
// csr      in         csr_we               csr_index, csr_wdata (no read-back)
//
// A pixel write does not stall req, so it is followed by the next item at once.
// A window yields (2*half+1)^2 elements, one element per cycle while rsp is not
// stalled; each element is registered in the walk state, then in the memory read stage.
// Reset clears control and loads register defaults; the pixel memory is not cleared.
// A stall on rsp freezes the element walk; req is stalled while a window is walked.

module padded_window_extractor (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  pwe_pkg::req_type               req,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output pwe_pkg::rsp_type               rsp,
   input  logic                           csr_we,
   input  logic [pwe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pwe_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pwe_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   pwe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req.cmd),
      .req_stall (req_stall),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   pwe_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req),
      .rsp       (rsp),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   // a taken element that is not the last is followed by the next position
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      $past(!reset && rsp_valid && !rsp_stall && !rsp.last)
      |-> rsp_valid && (rsp.window_pos == $past(rsp.window_pos) + WPOS_W'(1)))
      else $error("window element skipped or repeated");

   // a new window starts at position zero
   a_pos_restart: assert property (@(posedge clock) disable iff (reset)
      $past(!reset && rsp_valid && !rsp_stall && rsp.last) && rsp_valid
      |-> rsp.window_pos == '0)
      else $error("window did not restart at position zero");

   // no item is taken in the middle of a window
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.last |-> req_stall)
      else $error("request accepted mid-window");

   // an accepted window request blocks the input next cycle
   a_window_busy: assert property (@(posedge clock) disable iff (reset)
      $past(!reset && req_valid && !req_stall && (req.cmd == CMD_WINDOW))
      |-> req_stall)
      else $error("window request did not start a walk");

endmodule
